>>> hdl/jsu_pkg.sv
// Shared types, codes and constants for the JSON string unescaper.
// Used by jsu_step and json_string_unescape_utf8_top; no dependencies.
`default_nettype none

package jsu_pkg;

  // Escape modes of the byte decoder. The fourth code acts as normal mode.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  // Number of hex digits that follow a \u escape.
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  // Characters that the escape decoder recognizes.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;

  // Control characters produced by the single-letter escapes.
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // UTF-8 encoding limits and marks.
  localparam logic [15:0] UTF8_MAX1  = 16'h007F;
  localparam logic [15:0] UTF8_MAX2  = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [5:0]  UTF8_MASK  = 6'h3F;

  // Decision of the byte decoder for one fed byte.
  typedef struct packed {
    logic        emit;       // one byte goes out now
    logic [7:0]  emit_byte;
    logic [1:0]  mode;       // next escape mode
    logic [2:0]  cnt;        // next hex digit count
    logic [15:0] cp;         // next code point accumulator
    logic        hv;         // next all-digits-valid flag
    logic        wr_hex;     // store the byte in the digit buffer
    logic        utf;        // a complete \u escape: UTF-8 sequence starts
    logic        replay;     // a failed \u escape: 'u' goes out, digits replay
    logic [2:0]  rep_n;      // number of digits to replay
  } jsu_dec_t;

  // Length of the UTF-8 encoding of a 16-bit value, 1 to 3.
  function automatic logic [1:0] utf8_len(input logic [15:0] cp);
    logic [1:0] len;
    if (cp <= UTF8_MAX1) begin
      len = 2'd1;
    end else if (cp <= UTF8_MAX2) begin
      len = 2'd2;
    end else begin
      len = 2'd3;
    end
    return len;
  endfunction

  // Byte idx of the UTF-8 encoding of a 16-bit value.
  function automatic logic [7:0] utf8_byte(input logic [15:0] cp, input logic [1:0] idx);
    logic [7:0] b;
    b = cp[7:0];
    case (utf8_len(cp))
      2'd2: begin
        if (idx == 2'd0) begin
          b = UTF8_LEAD2 | {3'b000, cp[10:6]};
        end else begin
          b = UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK};
        end
      end
      2'd3: begin
        case (idx)
          2'd0:    b = UTF8_LEAD3 | {4'b0000, cp[15:12]};
          2'd1:    b = UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK};
          default: b = UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/jsu_step.sv
// Byte decoder: the shared unit that handles one fed byte, from the input or a replay.
// Depends on jsu_pkg for the escape codes, the decision struct and the UTF-8 helpers.
`default_nettype none

module jsu_step import jsu_pkg::*; (
  input  logic [1:0]  mode_i,
  input  logic [2:0]  cnt_i,
  input  logic [15:0] cp_i,
  input  logic        hv_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output jsu_dec_t    dec_o
);

  logic       is_hex;
  logic [3:0] nib;
  logic [2:0] cnt_inc;
  logic [15:0] cp_new;
  logic       hv_new;

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (byte_i >= CH_0 && byte_i <= CH_9) begin
      nib = byte_i[3:0];
    end else if ((byte_i >= CH_LA && byte_i <= CH_LF) ||
                 (byte_i >= CH_UA && byte_i <= CH_UF)) begin
      nib = byte_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign cnt_inc = cnt_i + 3'd1;
  assign cp_new  = {cp_i[11:0], nib};
  assign hv_new  = hv_i & is_hex;

  always_comb begin
    dec_o           = '0;
    dec_o.emit_byte = byte_i;
    dec_o.mode      = mode_i;
    dec_o.cnt       = cnt_i;
    dec_o.cp        = cp_i;
    dec_o.hv        = hv_i;
    dec_o.rep_n     = cnt_inc;
    case (mode_i)
      MODE_ESC: begin
        dec_o.mode = MODE_NORMAL;
        dec_o.emit = 1'b1;
        case (byte_i)
          CH_B: dec_o.emit_byte = CTL_BS;
          CH_F: dec_o.emit_byte = CTL_FF;
          CH_N: dec_o.emit_byte = CTL_LF;
          CH_R: dec_o.emit_byte = CTL_CR;
          CH_T: dec_o.emit_byte = CTL_HT;
          CH_U: begin
            // A \u at the very end goes out as a plain 'u'.
            if (!last_i) begin
              dec_o.emit = 1'b0;
              dec_o.mode = MODE_HEX;
              dec_o.cnt  = 3'd0;
              dec_o.cp   = 16'd0;
              dec_o.hv   = 1'b1;
            end
          end
          default: dec_o.emit_byte = byte_i;
        endcase
      end
      MODE_HEX: begin
        dec_o.wr_hex = 1'b1;
        dec_o.cnt    = cnt_inc;
        dec_o.cp     = cp_new;
        dec_o.hv     = hv_new;
        if (cnt_inc >= HEX_DIGITS && hv_new) begin
          dec_o.mode      = MODE_NORMAL;
          dec_o.cnt       = 3'd0;
          dec_o.utf       = 1'b1;
          dec_o.emit      = 1'b1;
          dec_o.emit_byte = utf8_byte(cp_new, 2'd0);
        end else if (cnt_inc >= HEX_DIGITS || last_i) begin
          dec_o.mode      = MODE_NORMAL;
          dec_o.cnt       = 3'd0;
          dec_o.replay    = 1'b1;
          dec_o.emit      = 1'b1;
          dec_o.emit_byte = CH_U;
        end
      end
      default: begin
        dec_o.mode = MODE_NORMAL;
        if (byte_i == CH_BACKSLASH && !last_i) begin
          dec_o.mode = MODE_ESC;
        end else begin
          dec_o.emit = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/jsu_obuf.sv
// Output register of the unescaper: holds one result item until the receiver takes it.
// No package dependencies.
`default_nettype none

module jsu_obuf (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  // The register can take a new item when empty or when its item leaves now.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = push_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

>>> hdl/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper with UTF-8 output for \u escapes.
// Depends on jsu_pkg, jsu_step (byte decoder) and jsu_obuf (output register).
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries the bytes between the
//   quotes of a JSON string literal, one byte per item, with in_last_i set on
//   the final byte. The output channel (out_valid_o / out_ready_i) carries the
//   unescaped bytes; out_last_o marks the final output byte of each string.
//   Both channels accept an item when valid and ready are high at a clock edge.
//
//   A small sequencer feeds one byte per step through the shared byte decoder.
//   The block takes one input item at a time: in_ready_o is high only while the
//   sequencer is idle. A plain byte passes through the accept, decode and
//   advance steps. Its result goes from the decode step into the output
//   register. A completed \u escape sends each further UTF-8 byte in turn from
//   the S_UTF state. A failed \u escape emits 'u' and then replays the up to
//   four collected bytes through the decoder, one byte at a time. Every input
//   item is thus handled by the single decoder, which handles one byte per step.
//
//   When the receiver stalls, the result waits in the output register and the
//   sequencer holds its step until that register frees; no byte is dropped.
//   Reset (rst_ni low, asynchronous) empties the output register and returns
//   the decoder to normal mode, ready for a new string.
`default_nettype none

module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an input item
  localparam logic [1:0] S_FEED = 2'd1;  // decoding the current byte
  localparam logic [1:0] S_UTF  = 2'd2;  // sending the rest of a UTF-8 sequence
  localparam logic [1:0] S_NEXT = 2'd3;  // fetching a replayed byte or finishing

  logic [1:0]  state_q, state_d;
  logic [7:0]  cur_byte_q, cur_byte_d;
  logic        cur_last_q, cur_last_d;
  logic [1:0]  mode_q, mode_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] cp_q, cp_d;
  logic        hv_q, hv_d;
  logic [2:0]  rep_n_q, rep_n_d;
  logic [2:0]  rep_idx_q, rep_idx_d;
  logic        rep_last_q, rep_last_d;
  logic [1:0]  utf_idx_q, utf_idx_d;

  // Bytes collected after \u. A replay reads them back in place: a replayed
  // byte can only overwrite an entry at least two places behind the one read.
  logic [7:0]  hex_q [HEX_DIGITS];
  logic        hex_we;

  jsu_dec_t    dec;
  logic        obuf_free;
  logic        commit;
  logic        push;
  logic [7:0]  push_byte;
  logic        push_last;
  logic [1:0]  utf_len_q;

  jsu_step u_step (
    .mode_i (mode_q),
    .cnt_i  (cnt_q),
    .cp_i   (cp_q),
    .hv_i   (hv_q),
    .byte_i (cur_byte_q),
    .last_i (cur_last_q),
    .dec_o  (dec)
  );

  jsu_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .byte_i      (push_byte),
    .last_i      (push_last),
    .free_o      (obuf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  // A decode step completes unless it must emit while the output register is full.
  assign commit     = !dec.emit || obuf_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign hex_we     = (state_q == S_FEED) && commit && dec.wr_hex;
  assign utf_len_q  = utf8_len(cp_q);

  always_comb begin
    state_d    = state_q;
    cur_byte_d = cur_byte_q;
    cur_last_d = cur_last_q;
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    cp_d       = cp_q;
    hv_d       = hv_q;
    rep_n_d    = rep_n_q;
    rep_idx_d  = rep_idx_q;
    rep_last_d = rep_last_q;
    utf_idx_d  = utf_idx_q;
    push       = 1'b0;
    push_byte  = dec.emit_byte;
    push_last  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_byte_d = in_byte_i;
          cur_last_d = in_last_i;
          state_d    = S_FEED;
        end
      end
      S_FEED: begin
        if (commit) begin
          push   = dec.emit;
          mode_d = dec.mode;
          cnt_d  = dec.cnt;
          cp_d   = dec.cp;
          hv_d   = dec.hv;
          if (dec.replay) begin
            // The 'u' of a failed escape is never the final byte: replay follows.
            rep_n_d    = dec.rep_n;
            rep_idx_d  = 3'd0;
            rep_last_d = cur_last_q;
            state_d    = S_NEXT;
          end else if (dec.utf && utf8_len(dec.cp) != 2'd1) begin
            utf_idx_d = 2'd1;
            state_d   = S_UTF;
          end else begin
            push_last = cur_last_q;
            state_d   = S_NEXT;
          end
        end
      end
      S_UTF: begin
        push_byte = utf8_byte(cp_q, utf_idx_q);
        if (obuf_free) begin
          push = 1'b1;
          if (utf_idx_q == utf_len_q - 2'd1) begin
            push_last = cur_last_q;
            state_d   = S_NEXT;
          end else begin
            utf_idx_d = utf_idx_q + 2'd1;
          end
        end
      end
      S_NEXT: begin
        if (rep_idx_q != rep_n_q) begin
          // The end mark travels with the last replayed byte only.
          cur_byte_d = hex_q[rep_idx_q[1:0]];
          cur_last_d = rep_last_q && ((rep_idx_q + 3'd1) == rep_n_q);
          rep_idx_d  = rep_idx_q + 3'd1;
          state_d    = S_FEED;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_last_q <= 1'b0;
      mode_q     <= MODE_NORMAL;
      cnt_q      <= 3'd0;
      cp_q       <= 16'd0;
      hv_q       <= 1'b1;
      rep_n_q    <= 3'd0;
      rep_idx_q  <= 3'd0;
      rep_last_q <= 1'b0;
      utf_idx_q  <= 2'd0;
    end else begin
      state_q    <= state_d;
      cur_last_q <= cur_last_d;
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      cp_q       <= cp_d;
      hv_q       <= hv_d;
      rep_n_q    <= rep_n_d;
      rep_idx_q  <= rep_idx_d;
      rep_last_q <= rep_last_d;
      utf_idx_q  <= utf_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_byte_q <= cur_byte_d;
  end

  always_ff @(posedge clk_i) begin
    if (hex_we) begin
      hex_q[cnt_q[1:0]] <= cur_byte_q;
    end
  end

  // The digit count stays below four between steps, so it always indexes the buffer.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cnt_q[2])
    else $error("hex digit count out of range");

  // A replay never reads past the bytes that were collected.
  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_idx_q <= rep_n_q)
    else $error("replay index beyond replay length");

  // A new input item is taken only when no replayed byte is still pending.
  a_no_rep_at_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (rep_idx_q == rep_n_q))
    else $error("input accepted with replay pending");

  // A decode step blocked by a full output register repeats on the same byte.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FEED && dec.emit && !obuf_free)
      |=> (state_q == S_FEED && $stable(cur_byte_q) && $stable(mode_q)))
    else $error("blocked decode step did not hold");

  // The sequencer only writes the output register when it can take the item.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> obuf_free)
    else $error("result written into a full output register");

endmodule

`default_nettype wire
